// File: rtl/lfpd_pkg.sv
// Shared types, constants and a helper function for the line follower PID drive.
package lfpd_pkg;

   localparam int SENSOR_COUNT = 5;
   localparam int SAMPLE_W     = 10;
   localparam int LEVEL_W      = 4;
   localparam int ERR_W        = 8;
   localparam int DIV_W        = 52;
   localparam int DIV_DIGIT    = 4;
   localparam int DIV_STEPS    = DIV_W / DIV_DIGIT;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

   localparam logic [SAMPLE_W-1:0] LEVEL_LO = 10'd120;
   localparam logic [SAMPLE_W-1:0] LEVEL_HI = 10'd130;

   // far left .. far right, in units of 1/20
   localparam logic signed [3:0] WEIGHT [SENSOR_COUNT] = '{-4'sd5, -4'sd2, 4'sd0, 4'sd2, 4'sd5};

   typedef logic [SENSOR_COUNT-1:0][SAMPLE_W-1:0] samples_type;

   typedef struct packed {
      logic start;
      logic by_ten;
      logic [DIV_W-1:0] dividend;
   } div_ctl_type;

   typedef struct packed {
      logic done;
      logic [DIV_W-1:0] quotient;
   } div_stat_type;

   // invert, clamp to 120..130, offset to 0..10
   function automatic logic [LEVEL_W-1:0] sensor_level(input logic [SAMPLE_W-1:0] raw);
      logic [SAMPLE_W-1:0] inv;
      logic [SAMPLE_W-1:0] ofs;
      logic [LEVEL_W-1:0]  lvl;
      inv = ~raw;
      ofs = inv - LEVEL_LO;
      if (inv > LEVEL_HI) begin
         lvl = LEVEL_W'(LEVEL_HI - LEVEL_LO);
      end else if (inv <= LEVEL_LO) begin
         lvl = '0;
      end else begin
         lvl = ofs[LEVEL_W-1:0];
      end
      return lvl;
   endfunction

endpackage

// File: rtl/lfpd_line_error.sv
// Weighted line error from the five clamped sensor levels.
module lfpd_line_error (
   input  lfpd_pkg::samples_type              samples,
   output logic signed [lfpd_pkg::ERR_W-1:0]  line_error
);

   always_comb begin
      logic signed [lfpd_pkg::ERR_W-1:0] sum;
      logic [lfpd_pkg::LEVEL_W-1:0]      lvl;
      logic signed [lfpd_pkg::ERR_W-1:0] w;
      logic signed [lfpd_pkg::ERR_W-1:0] l;
      sum = '0;
      for (int i = 0; i < lfpd_pkg::SENSOR_COUNT; i++) begin
         lvl = lfpd_pkg::sensor_level(samples[i]);
         w   = {{(lfpd_pkg::ERR_W-4){lfpd_pkg::WEIGHT[i][3]}}, lfpd_pkg::WEIGHT[i]};
         l   = $signed({{(lfpd_pkg::ERR_W-lfpd_pkg::LEVEL_W){1'b0}}, lvl});
         sum = sum + w * l;
      end
      line_error = sum;
   end

endmodule

// File: rtl/lfpd_const_div.sv
// Serial unsigned divider by 10 or 20, four quotient bits per cycle.
module lfpd_const_div (
   input  logic                  clock,
   input  logic                  reset,
   input  lfpd_pkg::div_ctl_type ctl,
   output lfpd_pkg::div_stat_type stat
);

   localparam logic [5:0] DIV_TEN    = 6'd10;
   localparam logic [5:0] DIV_TWENTY = 6'd20;

   logic [lfpd_pkg::DIV_W-1:0]     work_ff, work_in;
   logic [4:0]                     rem_ff, rem_in;
   logic [lfpd_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic                           ten_ff, ten_in;

   always_comb begin
      logic [4:0] r;
      logic [5:0] t;
      logic [5:0] d;
      logic [lfpd_pkg::DIV_DIGIT-1:0] q;
      work_in = work_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      ten_in  = ten_ff;
      d = ten_ff ? DIV_TEN : DIV_TWENTY;
      r = rem_ff;
      q = '0;
      for (int k = 0; k < lfpd_pkg::DIV_DIGIT; k++) begin
         t = {r, work_ff[lfpd_pkg::DIV_W-1-k]};
         if (t >= d) begin
            t = t - d;
            q[lfpd_pkg::DIV_DIGIT-1-k] = 1'b1;
         end
         r = t[4:0];
      end
      if (ctl.start) begin
         work_in = ctl.dividend;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
         ten_in  = ctl.by_ten;
      end else if (busy_ff) begin
         work_in = {work_ff[lfpd_pkg::DIV_W-lfpd_pkg::DIV_DIGIT-1:0], q};
         rem_in  = r;
         cnt_in  = cnt_ff + 1'b1;
         if (cnt_ff == lfpd_pkg::DIV_CNT_W'(lfpd_pkg::DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      work_ff <= work_in;
      rem_ff  <= rem_in;
      cnt_ff  <= cnt_in;
      ten_ff  <= ten_in;
   end

   assign stat.done     = done_ff;
   assign stat.quotient = work_ff;

   div_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a preceding busy cycle");

endmodule

// File: rtl/line_follower_pid_drive_unit.sv
// Line follower PID steering drive: top level with sequencer and shared multiplier.
//
// Requests arrive on req_ (five 10-bit sensor samples in req_tdata); each request
// yields exactly one response on rsp_ carrying the two saturated motor speeds and
// the drive enable flag. Gains, base speed and start delay sit on the csr_ APB
// port; the user must write them only while the block is idle, as the block
// itself does not enforce this. A request is taken only when the sequencer is
// idle. It then runs one shared 16x33 multiplier for the PID terms and one
// serial constant divider twice (divide by 20, then by 10 for the low-pass).
// The response sits in an output register: the next request is accepted while
// it waits, and that request's result holds back until rsp_tready takes the
// previous one.
// Reset loads the register defaults, clears the error, integral, filter and
// start-delay state, and drops rsp_tvalid.
module line_follower_pid_drive_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // sample_far_left, sample_left, sample_center,
                                   // sample_right, sample_far_right (10 bits each)
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // speed_one (9), speed_two (9), drive_enable (1)
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int ACC_W = 51;

   localparam logic [2:0] REG_GAIN_P      = 3'd0;
   localparam logic [2:0] REG_GAIN_I      = 3'd1;
   localparam logic [2:0] REG_GAIN_D      = 3'd2;
   localparam logic [2:0] REG_BASE_SPEED  = 3'd3;
   localparam logic [2:0] REG_START_DELAY = 3'd4;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_ERR    = 4'd1;
   localparam logic [3:0] S_MUL0   = 4'd2;
   localparam logic [3:0] S_MUL1   = 4'd3;
   localparam logic [3:0] S_MUL2   = 4'd4;
   localparam logic [3:0] S_MUL3   = 4'd5;
   localparam logic [3:0] S_START1 = 4'd6;
   localparam logic [3:0] S_DIV1   = 4'd7;
   localparam logic [3:0] S_SAT    = 4'd8;
   localparam logic [3:0] S_FILT   = 4'd9;
   localparam logic [3:0] S_START2 = 4'd10;
   localparam logic [3:0] S_DIV2   = 4'd11;
   localparam logic [3:0] S_OUT    = 4'd12;

   localparam logic signed [31:0] INT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] INT_MIN = 32'sh8000_0000;

   function automatic logic [8:0] sat_speed(input logic signed [25:0] v);
      logic [8:0] r;
      if (v > 26'sd255) begin
         r = 9'h0FF;
      end else if (v < -26'sd255) begin
         r = 9'h101;
      end else begin
         r = v[8:0];
      end
      return r;
   endfunction

   logic [15:0] gain_p_ff, gain_p_in;
   logic [15:0] gain_i_ff, gain_i_in;
   logic [15:0] gain_d_ff, gain_d_in;
   logic [7:0]  base_ff, base_in;
   logic [15:0] delay_ff, delay_in;

   logic [3:0]                          state_ff, state_in;
   logic signed [lfpd_pkg::ERR_W-1:0]   werr_ff, werr_in;
   logic signed [lfpd_pkg::ERR_W-1:0]   held_ff, held_in;
   logic signed [lfpd_pkg::ERR_W-1:0]   prev_ff, prev_in;
   logic signed [lfpd_pkg::ERR_W:0]     diff_ff, diff_in;
   logic signed [31:0]                  sum_ff, sum_in;
   logic signed [49:0]                  prod_ff, prod_in;
   logic signed [ACC_W-1:0]             acc_ff, acc_in;
   logic                                neg_ff, neg_in;
   logic signed [31:0]                  pid_ff, pid_in;
   logic signed [31:0]                  sd_ff, sd_in;
   logic [15:0]                         count_ff, count_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [18:0]                         rsp_data_ff, rsp_data_in;

   logic signed [lfpd_pkg::ERR_W-1:0] line_error;
   lfpd_pkg::samples_type             samples;
   lfpd_pkg::div_ctl_type             div_ctl;
   lfpd_pkg::div_stat_type            div_stat;

   logic [15:0]        mul_a;
   logic signed [32:0] mul_b;
   logic signed [49:0] mul_p;
   logic               req_fire;
   logic               csr_write;

   always_comb begin
      for (int i = 0; i < lfpd_pkg::SENSOR_COUNT; i++) begin
         samples[i] = req_tdata[i*lfpd_pkg::SAMPLE_W +: lfpd_pkg::SAMPLE_W];
      end
   end

   lfpd_line_error u_line_error (
      .samples    (samples),
      .line_error (line_error)
   );

   lfpd_const_div u_div (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .stat  (div_stat)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, rsp_data_ff};
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (csr_paddr[4:2])
         REG_GAIN_P:      csr_prdata = {16'b0, gain_p_ff};
         REG_GAIN_I:      csr_prdata = {16'b0, gain_i_ff};
         REG_GAIN_D:      csr_prdata = {16'b0, gain_d_ff};
         REG_BASE_SPEED:  csr_prdata = {24'b0, base_ff};
         REG_START_DELAY: csr_prdata = {16'b0, delay_ff};
         default:         csr_prdata = '0;
      endcase
   end

   always_comb begin
      gain_p_in = gain_p_ff;
      gain_i_in = gain_i_ff;
      gain_d_in = gain_d_ff;
      base_in   = base_ff;
      delay_in  = delay_ff;
      if (csr_write) begin
         case (csr_paddr[4:2])
            REG_GAIN_P:      gain_p_in = csr_pwdata[15:0];
            REG_GAIN_I:      gain_i_in = csr_pwdata[15:0];
            REG_GAIN_D:      gain_d_in = csr_pwdata[15:0];
            REG_BASE_SPEED:  base_in   = csr_pwdata[7:0];
            REG_START_DELAY: delay_in  = csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // shared multiplier operand select
   always_comb begin
      case (state_ff)
         S_MUL0: begin
            mul_a = gain_p_ff;
            mul_b = {{(33-lfpd_pkg::ERR_W){held_ff[lfpd_pkg::ERR_W-1]}}, held_ff};
         end
         S_MUL1: begin
            mul_a = gain_i_ff;
            mul_b = {sum_ff[31], sum_ff};
         end
         default: begin
            mul_a = gain_d_ff;
            mul_b = {{(32-lfpd_pkg::ERR_W){diff_ff[lfpd_pkg::ERR_W]}}, diff_ff};
         end
      endcase
      mul_p = $signed({1'b0, mul_a}) * mul_b;
   end

   always_comb begin
      logic signed [lfpd_pkg::ERR_W-1:0] e;
      logic signed [32:0]  s33;
      logic [ACC_W-1:0]    mag;
      logic [lfpd_pkg::DIV_W-1:0] q;
      logic signed [35:0]  sd36;
      logic signed [35:0]  fsum;
      logic signed [32:0]  sdb;
      logic signed [24:0]  drive;
      logic signed [25:0]  s1;
      logic signed [25:0]  s2;
      logic                en;

      state_in     = state_ff;
      werr_in      = werr_ff;
      held_in      = held_ff;
      prev_in      = prev_ff;
      diff_in      = diff_ff;
      sum_in       = sum_ff;
      prod_in      = prod_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      pid_in       = pid_ff;
      sd_in        = sd_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      div_ctl.start    = 1'b0;
      div_ctl.by_ten   = 1'b0;

      e   = (werr_ff >= 8'sd2 || werr_ff <= -8'sd2) ? werr_ff : held_ff;
      s33 = {sum_ff[31], sum_ff} + {{(33-lfpd_pkg::ERR_W){e[lfpd_pkg::ERR_W-1]}}, e};
      mag = acc_ff[ACC_W-1] ? (~acc_ff + 1'b1) : acc_ff;
      div_ctl.dividend = {{(lfpd_pkg::DIV_W-ACC_W){1'b0}}, mag};
      q    = div_stat.quotient;
      sd36 = {{4{sd_ff[31]}}, sd_ff};
      fsum = (sd36 <<< 3) + sd36 + {{4{pid_ff[31]}}, pid_ff};
      sdb  = {sd_ff[31], sd_ff} + (sd_ff[31] ? 33'sd255 : 33'sd0);
      drive = sdb[32:8];
      s1 = $signed({18'b0, base_ff}) + {drive[24], drive};
      s2 = $signed({18'b0, base_ff}) - {drive[24], drive};
      en = !(count_ff < delay_ff);

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               werr_in  = line_error;
               state_in = S_ERR;
            end
         end
         S_ERR: begin
            held_in = e;
            prev_in = e;
            diff_in = {e[lfpd_pkg::ERR_W-1], e} - {prev_ff[lfpd_pkg::ERR_W-1], prev_ff};
            if (s33[32] != s33[31]) begin
               sum_in = s33[32] ? INT_MIN : INT_MAX;
            end else begin
               sum_in = s33[31:0];
            end
            state_in = S_MUL0;
         end
         S_MUL0: begin
            prod_in  = mul_p;
            acc_in   = '0;
            state_in = S_MUL1;
         end
         S_MUL1, S_MUL2: begin
            prod_in  = mul_p;
            acc_in   = acc_ff + {prod_ff[49], prod_ff};
            state_in = (state_ff == S_MUL1) ? S_MUL2 : S_MUL3;
         end
         S_MUL3: begin
            acc_in   = acc_ff + {prod_ff[49], prod_ff};
            state_in = S_START1;
         end
         S_START1: begin
            div_ctl.start = 1'b1;
            neg_in   = acc_ff[ACC_W-1];
            state_in = S_DIV1;
         end
         S_DIV1: begin
            if (div_stat.done) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            if (neg_ff) begin
               if (q[lfpd_pkg::DIV_W-1:32] != '0 || (q[31] && q[30:0] != '0)) begin
                  pid_in = INT_MIN;
               end else begin
                  pid_in = -$signed(q[31:0]);
               end
            end else begin
               if (q[lfpd_pkg::DIV_W-1:31] != '0) begin
                  pid_in = INT_MAX;
               end else begin
                  pid_in = $signed({1'b0, q[30:0]});
               end
            end
            state_in = S_FILT;
         end
         S_FILT: begin
            acc_in   = {{(ACC_W-36){fsum[35]}}, fsum};
            state_in = S_START2;
         end
         S_START2: begin
            div_ctl.start  = 1'b1;
            div_ctl.by_ten = 1'b1;
            neg_in   = acc_ff[ACC_W-1];
            state_in = S_DIV2;
         end
         S_DIV2: begin
            if (div_stat.done) begin
               sd_in    = neg_ff ? -$signed(q[31:0]) : $signed(q[31:0]);
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {en, sat_speed(s2), sat_speed(s1)};
               if (!en) begin
                  count_in = count_ff + 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= 16'd14080;
         gain_i_ff    <= 16'd0;
         gain_d_ff    <= 16'd19200;
         base_ff      <= 8'd75;
         delay_ff     <= 16'd2000;
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         prev_ff      <= '0;
         sum_ff       <= '0;
         sd_ff        <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_p_ff    <= gain_p_in;
         gain_i_ff    <= gain_i_in;
         gain_d_ff    <= gain_d_in;
         base_ff      <= base_in;
         delay_ff     <= delay_in;
         state_ff     <= state_in;
         held_ff      <= held_in;
         prev_ff      <= prev_in;
         sum_ff       <= sum_in;
         sd_ff        <= sd_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      werr_ff     <= werr_in;
      diff_ff     <= diff_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      neg_ff      <= neg_in;
      pid_ff      <= pid_in;
      rsp_data_ff <= rsp_data_in;
   end

   held_never_small: assert property (@(posedge clock) disable iff (reset)
      held_ff != 8'sd1 && held_ff != -8'sd1)
      else $error("held error took a value inside the dead band");

   speed_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_data_ff[8:0] != 9'h100 && rsp_data_ff[17:9] != 9'h100)
      else $error("motor speed outside -255..255");

   accept_starts_run: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_ERR)
      else $error("accepted request did not start the sequencer");

   div_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> state_ff == S_DIV1 || state_ff == S_DIV2)
      else $error("divider finished outside a wait state");

endmodule
